// File: hw/rtl/evad_pkg.sv
// Shared constants, register indexes and types of the energy voice activity detector.
`default_nettype none

package evad_pkg;

  // Ring of recent magnitudes; the depth must be a power of two.
  localparam int WINDOW_DEPTH = 4096;
  localparam int RING_AW      = $clog2(WINDOW_DEPTH);
  localparam int WLEN_W       = RING_AW + 1;

  // Fixed field widths.
  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = 16;
  localparam int ALPHA_W    = 16;
  localparam int THR_W      = 16;
  localparam int THR_FRAC   = 12;
  localparam int ALPHA_FRAC = 15;

  // Accumulators.
  localparam int COUNT_BITS = 24;
  localparam int TOTAL_W    = 40;
  localparam int WIN_W      = 28;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_W-1:0]    TOTAL_MAX = '1;

  // Filter datapath: the difference term and its product with alpha.
  localparam int DIFF_W = SAMPLE_W + 2;
  localparam int FPROD_W = DIFF_W + ALPHA_W + 1;

  // Final cross multiplication, split into partial products.
  localparam int TOT_HALF = TOTAL_W / 2;
  localparam int LHS_W    = WIN_W + COUNT_BITS;
  localparam int TW_W     = THR_W + WLEN_W;
  localparam int PART_W   = TW_W + TOT_HALF;
  localparam int RHS_W    = PART_W + TOT_HALF;
  localparam int CMP_W    = (RHS_W > LHS_W + THR_FRAC) ? RHS_W : LHS_W + THR_FRAC;
  localparam int MUL_A_W  = (WIN_W > TW_W) ? WIN_W : TW_W;
  localparam int MUL_B_W0 = (COUNT_BITS > TOT_HALF) ? COUNT_BITS : TOT_HALF;
  localparam int MUL_B_W  = (MUL_B_W0 > WLEN_W) ? MUL_B_W0 : WLEN_W;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 2'd3;

  localparam logic [ALPHA_W-1:0] ALPHA_RST  = 16'd32768;
  localparam logic [WLEN_W-1:0]  WLEN_RST   = 13'd1000;
  localparam logic [THR_W-1:0]   THR_RST    = 16'd2458;

  // Filter output handed to the accumulators.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] y;
    logic        [MAG_W-1:0]    mag;
  } hpf_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/evad_if.sv
// Valid/ready channel interfaces for sample beats and result beats.
`default_nettype none

interface evad_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [evad_pkg::SAMPLE_W-1:0]  sample;
  logic                                  last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface evad_out_if;
  logic valid;
  logic ready;
  logic quiet_end;
  logic too_short;

  modport source (output valid, output quiet_end, output too_short, input ready);
  modport sink   (input valid, input quiet_end, input too_short, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/energy_voice_activity_detector.sv
// Top level of the energy voice activity detector.
//
//   channel | direction | beat                 | accepted when
//   --------+-----------+----------------------+----------------------
//   in_i    | sink      | sample, last         | valid && ready
//   out_o   | source    | quiet_end, too_short | valid && ready
//   cfg     | sink      | index, data          | cfg_we_i
//
// One sample beat is taken per clock while the block is ready for it. The
// magnitude ring RAM is written and read in the cycle a beat is taken; the
// window update uses the read data in the next cycle. After the last beat,
// the result passes through one accumulate step, four steps through a shared
// 29x24 multiplier and one compare step, during which no sample is taken; the
// next sample can be taken as soon as the result is registered. A result held
// on a stalled output waits in the output register; the next buffer's result
// then waits in the compare step, which keeps the input stalled. Reset needs
// no clearing pass of the ring.
`default_nettype none

module energy_voice_activity_detector (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  evad_in_if.sink                              in_i,
  evad_out_if.source                           out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [evad_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [evad_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int RAW = evad_pkg::RING_AW;
  localparam int WLW = evad_pkg::WLEN_W;
  localparam int CB  = evad_pkg::COUNT_BITS;
  localparam int TW  = evad_pkg::TOTAL_W;
  localparam int WW  = evad_pkg::WIN_W;
  localparam int HW  = evad_pkg::TOT_HALF;

  // Sequencer codes.
  localparam logic [2:0] ST_RUN = 3'd0;
  localparam logic [2:0] ST_LHS = 3'd1;
  localparam logic [2:0] ST_TW  = 3'd2;
  localparam logic [2:0] ST_LO  = 3'd3;
  localparam logic [2:0] ST_HI  = 3'd4;
  localparam logic [2:0] ST_CMP = 3'd5;

  // Configuration registers.
  logic                          filter_enable_q;
  logic [evad_pkg::ALPHA_W-1:0]  alpha_q;
  logic [WLW-1:0]                window_len_q;
  logic [evad_pkg::THR_W-1:0]    threshold_q;

  // Buffer state.
  logic signed [evad_pkg::SAMPLE_W-1:0] prev_raw_q, prev_raw_d;
  logic signed [evad_pkg::SAMPLE_W-1:0] filtered_q, filtered_d;
  logic [CB-1:0]  count_q, count_d;
  logic [TW-1:0]  total_q, total_d;
  logic [WW-1:0]  window_q, window_d;
  logic [RAW-1:0] ptr_q, ptr_d;
  logic [2:0]     state_q, state_d;

  // Accumulate stage.
  logic                        s1_valid_q;
  logic                        s1_last_q;
  logic                        s1_sub_q;
  logic [evad_pkg::MAG_W-1:0]  s1_mag_q;

  // Final products.
  logic [evad_pkg::LHS_W-1:0]  lhs_q;
  logic [evad_pkg::TW_W-1:0]   tw_q;
  logic [evad_pkg::PART_W-1:0] plo_q;
  logic [evad_pkg::PART_W-1:0] phi_q;

  // Output register.
  logic out_valid_q, out_valid_d;
  logic out_quiet_q, out_short_q;

  logic                        in_fire;
  logic                        clear_buf;
  logic                        emit;
  logic [WLW-1:0]              wlen;
  logic [RAW-1:0]              old_addr;
  logic [evad_pkg::MAG_W-1:0]  ring_rdata;
  evad_pkg::hpf_res_t          hpf_res;
  logic [TW:0]                 total_sum;
  logic [evad_pkg::MUL_A_W-1:0] mul_a;
  logic [evad_pkg::MUL_B_W-1:0] mul_b;
  logic [evad_pkg::MUL_P_W-1:0] mul_p;
  logic [evad_pkg::CMP_W-1:0]  rhs;
  logic [evad_pkg::CMP_W-1:0]  lhs_ext;
  logic                        too_short;
  logic                        quiet;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_enable_q <= 1'b0;
      alpha_q         <= evad_pkg::ALPHA_RST;
      window_len_q    <= evad_pkg::WLEN_RST;
      threshold_q     <= evad_pkg::THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        evad_pkg::CFG_FILTER_ENABLE: filter_enable_q <= cfg_data_i[0];
        evad_pkg::CFG_ALPHA:         alpha_q         <= cfg_data_i[evad_pkg::ALPHA_W-1:0];
        evad_pkg::CFG_WINDOW_LEN:    window_len_q    <= cfg_data_i[WLW-1:0];
        evad_pkg::CFG_THRESHOLD:     threshold_q     <= cfg_data_i[evad_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Window length clamped to one through the ring depth.
  always_comb begin
    if (window_len_q == '0) begin
      wlen = WLW'(1);
    end else if (window_len_q > WLW'(evad_pkg::WINDOW_DEPTH)) begin
      wlen = WLW'(evad_pkg::WINDOW_DEPTH);
    end else begin
      wlen = window_len_q;
    end
  end

  assign in_i.ready = (state_q == ST_RUN) && !(s1_valid_q && s1_last_q);
  assign in_fire    = in_i.valid && in_i.ready;

  // Filter step; the first sample of a buffer, and every sample while the filter is disabled, passes unchanged.
  evad_hpf u_hpf (
    .sample_i   (in_i.sample),
    .prev_raw_i (prev_raw_q),
    .filtered_i (filtered_q),
    .alpha_i    (alpha_q),
    .bypass_i   ((count_q == '0) || !filter_enable_q),
    .res_o      (hpf_res)
  );

  // Ring of magnitudes: write the new one, read the one leaving the window.
  assign old_addr = ptr_q - wlen[RAW-1:0];

  evad_ram #(
    .WIDTH (evad_pkg::MAG_W),
    .DEPTH (evad_pkg::WINDOW_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i (ptr_q),
    .wdata_i (hpf_res.mag),
    .re_i    (in_fire),
    .raddr_i (old_addr),
    .rdata_o (ring_rdata)
  );

  // Accumulate stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
      s1_last_q  <= in_fire && in_i.last;
    end
  end

  // Accumulate stage payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_mag_q <= hpf_res.mag;
      s1_sub_q <= count_q >= CB'(wlen);
    end
  end

  assign total_sum = {1'b0, total_q} + (TW + 1)'(s1_mag_q);
  assign emit      = (state_q == ST_CMP) && (!out_valid_q || out_o.ready);
  assign clear_buf = emit;

  // Buffer state update.
  always_comb begin
    prev_raw_d = prev_raw_q;
    filtered_d = filtered_q;
    count_d    = count_q;
    ptr_d      = ptr_q;
    total_d    = total_q;
    window_d   = window_q;
    if (in_fire) begin
      prev_raw_d = in_i.sample;
      filtered_d = hpf_res.y;
      count_d    = (count_q == evad_pkg::COUNT_MAX) ? count_q : count_q + CB'(1);
      ptr_d      = ptr_q + RAW'(1);
    end
    if (s1_valid_q) begin
      total_d  = total_sum[TW] ? evad_pkg::TOTAL_MAX : total_sum[TW-1:0];
      window_d = window_q - (s1_sub_q ? WW'(ring_rdata) : WW'(0)) + WW'(s1_mag_q);
    end
    if (clear_buf) begin
      prev_raw_d = '0;
      filtered_d = '0;
      count_d    = '0;
      ptr_d      = '0;
      total_d    = '0;
      window_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_raw_q <= '0;
      filtered_q <= '0;
      count_q    <= '0;
      ptr_q      <= '0;
      total_q    <= '0;
      window_q   <= '0;
    end else begin
      prev_raw_q <= prev_raw_d;
      filtered_q <= filtered_d;
      count_q    <= count_d;
      ptr_q      <= ptr_d;
      total_q    <= total_d;
      window_q   <= window_d;
    end
  end

  // End-of-buffer sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RUN: begin
        if (s1_valid_q && s1_last_q) begin
          state_d = ST_LHS;
        end
      end
      ST_LHS: state_d = ST_TW;
      ST_TW:  state_d = ST_LO;
      ST_LO:  state_d = ST_HI;
      ST_HI:  state_d = ST_CMP;
      ST_CMP: begin
        if (emit) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  // Shared multiplier operands for the cross multiplication.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_LHS: begin
        mul_a = evad_pkg::MUL_A_W'(window_q);
        mul_b = evad_pkg::MUL_B_W'(count_q);
      end
      ST_TW: begin
        mul_a = evad_pkg::MUL_A_W'(threshold_q);
        mul_b = evad_pkg::MUL_B_W'(wlen);
      end
      ST_LO: begin
        mul_a = evad_pkg::MUL_A_W'(tw_q);
        mul_b = evad_pkg::MUL_B_W'(total_q[HW-1:0]);
      end
      ST_HI: begin
        mul_a = evad_pkg::MUL_A_W'(tw_q);
        mul_b = evad_pkg::MUL_B_W'(total_q[TW-1:HW]);
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_LHS:  lhs_q <= mul_p[evad_pkg::LHS_W-1:0];
      ST_TW:   tw_q  <= mul_p[evad_pkg::TW_W-1:0];
      ST_LO:   plo_q <= mul_p[evad_pkg::PART_W-1:0];
      ST_HI:   phi_q <= mul_p[evad_pkg::PART_W-1:0];
      default: ;
    endcase
  end

  // Window average against threshold times overall average, cross multiplied.
  assign rhs       = evad_pkg::CMP_W'(plo_q) + (evad_pkg::CMP_W'(phi_q) << HW);
  assign lhs_ext   = evad_pkg::CMP_W'(lhs_q) << evad_pkg::THR_FRAC;
  assign too_short = count_q <= CB'(wlen);
  assign quiet     = !too_short && !(lhs_ext > rhs);

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_quiet_q <= quiet;
      out_short_q <= too_short;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.quiet_end = out_quiet_q;
  assign out_o.too_short = out_short_q;

endmodule

`default_nettype wire

// File: hw/rtl/evad_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module evad_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/evad_hpf.sv
// First-order high-pass filter step with rounding, saturation and magnitude.
`default_nettype none

module evad_hpf (
  input  wire logic signed [evad_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic signed [evad_pkg::SAMPLE_W-1:0] prev_raw_i,
  input  wire logic signed [evad_pkg::SAMPLE_W-1:0] filtered_i,
  input  wire logic        [evad_pkg::ALPHA_W-1:0]  alpha_i,
  input  wire logic                                 bypass_i,
  output      evad_pkg::hpf_res_t                   res_o
);

  localparam int SH_W = evad_pkg::FPROD_W - evad_pkg::ALPHA_FRAC;

  logic signed [evad_pkg::DIFF_W-1:0]   diff;
  logic signed [evad_pkg::FPROD_W-1:0]  prod;
  logic signed [evad_pkg::FPROD_W-1:0]  rnd;
  logic signed [SH_W-1:0]               shifted;
  logic signed [evad_pkg::SAMPLE_W-1:0] sat;
  logic signed [evad_pkg::SAMPLE_W-1:0] y;

  // Difference term y + x - x_prev, then scale by alpha in unsigned Q1.15.
  assign diff = evad_pkg::DIFF_W'(filtered_i) + evad_pkg::DIFF_W'(sample_i)
              - evad_pkg::DIFF_W'(prev_raw_i);
  assign prod = $signed({1'b0, alpha_i}) * diff;
  assign rnd  = prod + evad_pkg::FPROD_W'(1 << (evad_pkg::ALPHA_FRAC - 1));
  assign shifted = rnd[evad_pkg::FPROD_W-1:evad_pkg::ALPHA_FRAC];

  // Saturate the rounded result to the sample range.
  always_comb begin
    if (shifted > SH_W'(32767)) begin
      sat = 16'sh7fff;
    end else if (shifted < -SH_W'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = shifted[evad_pkg::SAMPLE_W-1:0];
    end
  end

  assign y = bypass_i ? sample_i : sat;

  // The most negative sample gives a magnitude of exactly full scale.
  assign res_o.y   = y;
  assign res_o.mag = y[evad_pkg::SAMPLE_W-1] ? (~y + 1'b1) : y;

endmodule

`default_nettype wire

// File: hw/rtl/evad_checker.sv
// Port-level checks of the voice activity detector, bound to its top level.
`default_nettype none

module evad_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic in_last_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic out_quiet_i,
  input wire logic out_short_i
);

  // A last beat stalls the input for the end-of-buffer evaluation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_last_i) |=> !in_ready_i)
    else $error("input taken right after a last beat");

  // A result rises only after the input has been held not ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result raised while samples were being taken");

  // A buffer judged too short never reports a quiet end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_quiet_i && out_short_i))
    else $error("quiet_end and too_short both set");

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_quiet_i) && $stable(out_short_i)))
    else $error("stalled result beat changed");

endmodule

bind energy_voice_activity_detector evad_checker u_evad_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_quiet_i (out_o.quiet_end),
  .out_short_i (out_o.too_short)
);

`default_nettype wire

// File: tb/energy_voice_activity_detector_test.sv
// Self-checking testbench for the energy voice activity detector.
`default_nettype none

module energy_voice_activity_detector_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    logic quiet_end;
    logic too_short;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                            cfg_we;
  logic [evad_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [evad_pkg::CFG_DATA_W-1:0] cfg_data;

  evad_in_if  sample_ch ();
  evad_out_if verdict_ch ();

  energy_voice_activity_detector DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (sample_ch),
    .out_o       (verdict_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the registers and of the per-buffer state.
  logic                                 hp_enable;
  logic [evad_pkg::ALPHA_W-1:0]         hp_alpha;
  logic [evad_pkg::WLEN_W-1:0]          win_len_reg;
  logic [evad_pkg::THR_W-1:0]           thr_reg;
  logic signed [evad_pkg::SAMPLE_W-1:0] last_raw;
  logic signed [evad_pkg::SAMPLE_W-1:0] last_filt;
  logic [evad_pkg::COUNT_BITS-1:0]      shadow_count;
  logic [evad_pkg::TOTAL_W-1:0]         energy_total;
  logic [evad_pkg::WIN_W-1:0]           energy_window;
  logic [evad_pkg::MAG_W-1:0]           mag_ring [evad_pkg::WINDOW_DEPTH];
  logic [evad_pkg::RING_AW-1:0]         ring_wr;

  verdict_t expected_verdicts [$];

  int          send_idle_pct   = 0;
  int          recv_stall_pct  = 0;
  int          hold_off_cycles = 0;
  int unsigned beats_sent      = 0;
  int unsigned buffers_sent    = 0;
  int unsigned verdicts_seen   = 0;
  int unsigned mismatches      = 0;

  function automatic void clear_buffer_totals();
    last_raw      = '0;
    last_filt     = '0;
    shadow_count  = '0;
    energy_total  = '0;
    energy_window = '0;
    ring_wr       = '0;
  endfunction

  function automatic int effective_window();
    if (win_len_reg == 0) return 1;
    if (win_len_reg > evad_pkg::WINDOW_DEPTH) return evad_pkg::WINDOW_DEPTH;
    return int'(win_len_reg);
  endfunction

  // Filter one accepted sample, update the energy sums and, on the final
  // sample of a buffer, queue the verdict that the block must report.
  function automatic void accumulate_energy(
      input logic signed [evad_pkg::SAMPLE_W-1:0] x,
      input logic is_last);
    int unsigned                          wlen;
    longint                               diff;
    longint                               prod;
    logic signed [evad_pkg::SAMPLE_W-1:0] y;
    logic [evad_pkg::MAG_W-1:0]           mag;
    logic [evad_pkg::RING_AW-1:0]         old_idx;
    logic [evad_pkg::TOTAL_W:0]           sum;
    logic [127:0]                         lhs;
    logic [127:0]                         rhs;
    verdict_t                             v;

    wlen = effective_window();

    // The first sample of a buffer and the bypass pass straight through.
    if (shadow_count == 0 || !hp_enable) begin
      y = x;
    end else begin
      diff = longint'(last_filt) + longint'(x) - longint'(last_raw);
      prod = (longint'(hp_alpha) * diff + 16384) >>> evad_pkg::ALPHA_FRAC;
      if (prod > 32767) prod = 32767;
      if (prod < -32768) prod = -32768;
      y = evad_pkg::SAMPLE_W'(prod);
    end
    last_raw  = x;
    last_filt = y;
    mag = (y < 0) ? evad_pkg::MAG_W'(-int'(y)) : evad_pkg::MAG_W'(y);

    // Sliding window: drop the magnitude that falls out, then add the new one.
    if (shadow_count >= wlen) begin
      old_idx = ring_wr - evad_pkg::RING_AW'(wlen);
      energy_window = energy_window - evad_pkg::WIN_W'(mag_ring[old_idx]);
    end
    mag_ring[ring_wr] = mag;
    energy_window = energy_window + evad_pkg::WIN_W'(mag);
    ring_wr = ring_wr + 1'b1;

    // Overall total and count, both saturating.
    sum = energy_total + mag;
    energy_total = (sum > evad_pkg::TOTAL_MAX) ? evad_pkg::TOTAL_MAX
                                               : sum[evad_pkg::TOTAL_W-1:0];
    if (shadow_count != evad_pkg::COUNT_MAX) shadow_count = shadow_count + 1'b1;

    if (!is_last) return;

    if (shadow_count <= wlen) begin
      v.quiet_end = 1'b0;
      v.too_short = 1'b1;
    end else begin
      lhs = 128'(energy_window) * 128'(shadow_count) * (128'(1) << evad_pkg::THR_FRAC);
      rhs = 128'(thr_reg) * 128'(energy_total) * 128'(wlen);
      v.quiet_end = (lhs <= rhs);
      v.too_short = 1'b0;
    end
    expected_verdicts.push_back(v);
    clear_buffer_totals();
  endfunction

  // Receiver: compare each verdict beat, then decide next cycle's ready.
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni === 1'b1 && verdict_ch.valid === 1'b1 && verdict_ch.ready === 1'b1) begin
      verdicts_seen++;
      if (expected_verdicts.size() == 0) begin
        $error("Verdict beat arrived with none expected (quiet_end=%0b too_short=%0b)",
               verdict_ch.quiet_end, verdict_ch.too_short);
        mismatches++;
      end else begin
        want = expected_verdicts.pop_front();
        if (verdict_ch.quiet_end !== want.quiet_end) begin
          $error("quiet_end: expected %0b, got %0b", want.quiet_end, verdict_ch.quiet_end);
          mismatches++;
        end
        if (verdict_ch.too_short !== want.too_short) begin
          $error("too_short: expected %0b, got %0b", want.too_short, verdict_ch.too_short);
          mismatches++;
        end
      end
    end
    if (hold_off_cycles > 0) begin
      verdict_ch.ready <= 1'b0;
      hold_off_cycles = hold_off_cycles - 1;
    end else begin
      verdict_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one sample beat, idling first at random, and wait for the handshake.
  task automatic send_sample(input logic signed [evad_pkg::SAMPLE_W-1:0] value,
                             input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= value;
    sample_ch.last   <= is_last;
    @(posedge clk_i);
    while (sample_ch.ready !== 1'b1) @(posedge clk_i);
    accumulate_energy(value, is_last);
    beats_sent++;
  endtask

  function automatic logic signed [evad_pkg::SAMPLE_W-1:0] pick_sample(input int amp);
    int v;
    v = int'($urandom_range(0, 2 * amp)) - amp;
    if (v > 32767) v = 32767;
    return evad_pkg::SAMPLE_W'(v);
  endfunction

  function automatic int pick_amplitude();
    case ($urandom_range(3))
      0:       return 0;
      1:       return $urandom_range(1, 64);
      2:       return $urandom_range(65, 4096);
      default: return $urandom_range(4097, 32768);
    endcase
  endfunction

  // One buffer: a head at one loudness and a tail at another.
  task automatic send_buffer(input int len, input int head_amp, input int tail_amp,
                             input int tail_len);
    for (int i = 0; i < len; i++) begin
      send_sample(pick_sample((i < len - tail_len) ? head_amp : tail_amp), i == len - 1);
    end
    buffers_sent++;
  endtask

  // Stop offering beats until every verdict is in and the block is idle.
  task automatic wait_for_verdicts();
    sample_ch.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all four registers on an idle block and mirror them in the shadow.
  task automatic configure(input logic [evad_pkg::CFG_DATA_W-1:0] en_word,
                           input logic [evad_pkg::CFG_DATA_W-1:0] alpha_word,
                           input logic [evad_pkg::CFG_DATA_W-1:0] wlen_word,
                           input logic [evad_pkg::CFG_DATA_W-1:0] thr_word);
    logic [evad_pkg::CFG_IDX_W-1:0]  regs [4];
    logic [evad_pkg::CFG_DATA_W-1:0] vals [4];
    wait_for_verdicts();
    regs = '{evad_pkg::CFG_FILTER_ENABLE, evad_pkg::CFG_ALPHA,
             evad_pkg::CFG_WINDOW_LEN, evad_pkg::CFG_THRESHOLD};
    vals = '{en_word, alpha_word, wlen_word, thr_word};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk_i);
    end
    cfg_we      <= 1'b0;
    hp_enable   = en_word[0];
    hp_alpha    = alpha_word;
    win_len_reg = wlen_word[evad_pkg::WLEN_W-1:0];
    thr_reg     = thr_word;
  endtask

  task automatic reconfigure_random();
    logic [evad_pkg::CFG_DATA_W-1:0] a;
    logic [evad_pkg::CFG_DATA_W-1:0] w;
    logic [evad_pkg::CFG_DATA_W-1:0] t;
    case ($urandom_range(3))
      0:       a = evad_pkg::ALPHA_RST;
      1:       a = evad_pkg::CFG_DATA_W'($urandom_range(28000, 32767));
      2:       a = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: a = evad_pkg::CFG_DATA_W'($urandom());
    endcase
    case ($urandom_range(7))
      0:       w = 16'd0;
      1:       w = evad_pkg::CFG_DATA_W'($urandom_range(25, 48));
      default: w = evad_pkg::CFG_DATA_W'($urandom_range(1, 24));
    endcase
    // Bits above the register width are ignored by the block.
    w[evad_pkg::CFG_DATA_W-1:evad_pkg::WLEN_W] = 3'($urandom_range(7));
    case ($urandom_range(3))
      0:       t = evad_pkg::CFG_DATA_W'($urandom_range(2048, 12288));
      1:       t = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: t = evad_pkg::CFG_DATA_W'($urandom());
    endcase
    configure({15'($urandom()), 1'($urandom_range(1))}, a, w, t);
  endtask

  // Registers as they come out of reset; includes a one-sample buffer.
  task automatic test_reset_defaults();
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd12345, 1'b1);
    buffers_sent += 2;
  endtask

  // Filter with gain above one drives the output into saturation; zero gain mutes it after the first sample.
  task automatic test_filter_saturation();
    configure(16'd1, 16'hFFFF, 16'd1, 16'd4096);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b1);
    configure(16'd1, 16'd0, 16'd2, 16'hFFFF);
    send_sample(16'sd1000, 1'b0);
    send_sample(-16'sd1000, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd7, 1'b1);
    buffers_sent += 2;
  endtask

  // A window length of zero acts as one; thresholds at both ends.
  task automatic test_window_bounds();
    configure(16'd0, evad_pkg::ALPHA_RST, 16'd0, 16'd0);
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd200, 1'b0);
    send_sample(16'sd300, 1'b1);
    configure(16'd0, evad_pkg::ALPHA_RST, 16'd1, 16'd0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);
    configure(16'd0, evad_pkg::ALPHA_RST, 16'd1, 16'hFFFF);
    send_sample(-16'sd300, 1'b0);
    send_sample(16'sd20, 1'b1);
    buffers_sent += 3;
  endtask

  // The receiver holds off while short buffers keep coming, so the block
  // must stall its input; afterwards the sender waits for every verdict.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    configure(16'd0, evad_pkg::ALPHA_RST, 16'd2, 16'd4096);
    hold_off_cycles = 300;
    for (int i = 0; i < 40; i++) begin
      send_buffer(3, 32768, pick_amplitude(), 1);
    end
    wait_for_verdicts();
  endtask

  // An oversized window length acts as the full ring depth, so a buffer
  // shorter than the ring is judged too short.
  task automatic test_long_window();
    configure(16'd1, 16'd31000, 16'h1FFF, 16'd4096);
    send_buffer(96, 20000, 200, 30);
    wait_for_verdicts();
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct, input int n_items);
    int unsigned first;
    int          w;
    int          len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    first = beats_sent;
    while (beats_sent - first < n_items) begin
      if (buffers_sent % 12 == 0) reconfigure_random();
      w   = effective_window();
      len = $urandom_range(1, 3 * w + 6);
      send_buffer(len, pick_amplitude(), pick_amplitude(), $urandom_range(0, len));
    end
    wait_for_verdicts();
  endtask

  // Random buffers under each idling pattern.
  task automatic test_random_traffic();
    run_random_phase(0, 0, 140);
    run_random_phase(75, 0, 140);
    run_random_phase(0, 75, 140);
    run_random_phase(20, 20, 140);
  endtask

  initial begin
    rst_ni           <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= evad_pkg::CFG_FILTER_ENABLE;
    cfg_data         <= '0;
    sample_ch.valid  <= 1'b0;
    sample_ch.sample <= '0;
    sample_ch.last   <= 1'b0;
    hp_enable   = 1'b0;
    hp_alpha    = evad_pkg::ALPHA_RST;
    win_len_reg = evad_pkg::WLEN_RST;
    thr_reg     = evad_pkg::THR_RST;
    clear_buffer_totals();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_filter_saturation();
    test_window_bounds();
    test_output_backpressure();
    test_long_window();
    test_random_traffic();

    wait_for_verdicts();
    $display("Sent %0d sample beats in %0d buffers and checked %0d verdict beats,",
             beats_sent, buffers_sent, verdicts_seen);
    $display("covering filter gain, window and threshold extremes under idle and stall.");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
